FILE: src/rpw_pkg.sv
package rpw_pkg;

   // Field widths of the result beat and the register port
   localparam int FIELD_W      = 15;
   localparam int PCT_W        = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 5;
   localparam int REG_IDX_W    = 3;

   // Default count width of the high-time counter
   localparam int COUNT_BITS_DEF = 15;

   // Reset values of the bound registers and the deadband
   localparam logic [FIELD_W-1:0] LOW_RESET  = 15'd1000;
   localparam logic [FIELD_W-1:0] MID_RESET  = 15'd1500;
   localparam logic [FIELD_W-1:0] HIGH_RESET = 15'd2000;
   localparam logic [FIELD_W-1:0] TOL_RESET  = 15'd50;

   // Scaling: percent = floor((w - low) * SCALE_SPAN / (high - low)) - SCALE_OFFSET
   localparam int SCALE_SPAN   = 200;
   localparam int SCALE_OFFSET = 100;
   localparam int QUOT_W       = 8;
   localparam int STEP_W       = $clog2(QUOT_W);

   // Register map, word index = paddr[4:2]
   typedef enum logic [REG_IDX_W-1:0] {
      REG_LOW_BOUND  = 3'd0,
      REG_MID_BOUND  = 3'd1,
      REG_HIGH_BOUND = 3'd2,
      REG_TOLERANCE  = 3'd3,
      REG_CALIBRATE  = 3'd4
   } reg_idx_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL_BOUND,
      ST_CAL_MID,
      ST_CLAMP,
      ST_SCALE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // Bound register writes from the register block
   typedef struct packed {
      logic               wr_low;
      logic               wr_mid;
      logic               wr_high;
      logic [FIELD_W-1:0] data;
   } bound_wr_type;

   // Controller to datapath
   typedef struct packed {
      logic tick;
      logic cal_bound;
      logic cal_mid;
      logic clamp;
      logic scale;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pulse_end;
   } dp_status_type;

endpackage

FILE: src/rpw_csr.sv
module rpw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rpw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rpw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rpw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output rpw_pkg::bound_wr_type          bound_wr,
   output logic [rpw_pkg::FIELD_W-1:0]    tolerance,
   output logic                          calibrate
);
   import rpw_pkg::*;

   logic [FIELD_W-1:0] low_ff, low_in;
   logic [FIELD_W-1:0] mid_ff, mid_in;
   logic [FIELD_W-1:0] high_ff, high_in;
   logic [FIELD_W-1:0] tol_ff, tol_in;
   logic               cal_ff, cal_in;
   logic               wr_en;
   reg_idx_type        idx;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign idx   = reg_idx_type'(csr_paddr[REG_IDX_W+1:2]);

   // Write decode
   always_comb begin
      low_in  = low_ff;
      mid_in  = mid_ff;
      high_in = high_ff;
      tol_in  = tol_ff;
      cal_in  = cal_ff;
      bound_wr.wr_low  = 1'b0;
      bound_wr.wr_mid  = 1'b0;
      bound_wr.wr_high = 1'b0;
      bound_wr.data    = csr_pwdata[FIELD_W-1:0];
      if (wr_en) begin
         unique case (idx)
            REG_LOW_BOUND: begin
               low_in = csr_pwdata[FIELD_W-1:0];
               bound_wr.wr_low = 1'b1;
            end
            REG_MID_BOUND: begin
               mid_in = csr_pwdata[FIELD_W-1:0];
               bound_wr.wr_mid = 1'b1;
            end
            REG_HIGH_BOUND: begin
               high_in = csr_pwdata[FIELD_W-1:0];
               bound_wr.wr_high = 1'b1;
            end
            REG_TOLERANCE: tol_in = csr_pwdata[FIELD_W-1:0];
            REG_CALIBRATE: cal_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LOW_RESET;
         mid_ff  <= MID_RESET;
         high_ff <= HIGH_RESET;
         tol_ff  <= TOL_RESET;
         cal_ff  <= 1'b0;
      end else begin
         low_ff  <= low_in;
         mid_ff  <= mid_in;
         high_ff <= high_in;
         tol_ff  <= tol_in;
         cal_ff  <= cal_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         REG_LOW_BOUND:  csr_prdata = CSR_DATA_W'(low_ff);
         REG_MID_BOUND:  csr_prdata = CSR_DATA_W'(mid_ff);
         REG_HIGH_BOUND: csr_prdata = CSR_DATA_W'(high_ff);
         REG_TOLERANCE:  csr_prdata = CSR_DATA_W'(tol_ff);
         REG_CALIBRATE:  csr_prdata = CSR_DATA_W'(cal_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign tolerance = tol_ff;
   assign calibrate = cal_ff;

endmodule

FILE: src/rpw_ctrl.sv
module rpw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rpw_pkg::dp_cmd_type    cmd,
   input  rpw_pkg::dp_status_type status
);
   import rpw_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic              accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = valid_ff;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      valid_in = valid_ff & rsp_stall;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.tick = accept;
            if (accept && status.pulse_end) begin
               state_in = ST_CAL_BOUND;
            end
         end
         ST_CAL_BOUND: begin
            cmd.cal_bound = 1'b1;
            state_in = ST_CAL_MID;
         end
         ST_CAL_MID: begin
            cmd.cal_mid = 1'b1;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            step_in = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: src/rpw_dp.sv
module rpw_dp #(
   parameter int COUNT_BITS = rpw_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rpw_pkg::dp_cmd_type            cmd,
   output rpw_pkg::dp_status_type         status,
   input  logic                           req_pin_level,
   input  rpw_pkg::bound_wr_type          bound_wr,
   input  logic [rpw_pkg::FIELD_W-1:0]    tolerance,
   input  logic                           calibrate,
   output logic [rpw_pkg::FIELD_W-1:0]    rsp_pulse_width,
   output logic signed [rpw_pkg::PCT_W-1:0] rsp_percent,
   output logic [rpw_pkg::FIELD_W-1:0]    rsp_low_bound,
   output logic [rpw_pkg::FIELD_W-1:0]    rsp_mid_bound,
   output logic [rpw_pkg::FIELD_W-1:0]    rsp_high_bound
);
   import rpw_pkg::*;

   // Working width holds both the count and the configured bounds
   localparam int WB = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
   localparam int NW = WB + QUOT_W;
   localparam int SW = WB + 2;

   // Edge tracking and counter
   logic                  prev_ff, prev_in;
   logic                  armed_ff, armed_in;
   logic [COUNT_BITS-1:0] ticks_ff, ticks_in;
   logic [WB-1:0]         width_ff, width_in;
   // Working bounds
   logic [WB-1:0]         low_ff, low_in;
   logic [WB-1:0]         mid_ff, mid_in;
   logic [WB-1:0]         high_ff, high_in;
   // Conversion
   logic [WB-1:0]         r_ff, r_in;
   logic                  zero_ff, zero_in;
   logic [NW-1:0]         rem_ff, rem_in;
   logic [NW-1:0]         div_ff, div_in;
   logic [QUOT_W-1:0]     quot_ff, quot_in;
   // Result beat
   logic [FIELD_W-1:0]    o_width_ff, o_width_in;
   logic [PCT_W-1:0]      o_pct_ff, o_pct_in;
   logic [FIELD_W-1:0]    o_low_ff, o_low_in;
   logic [FIELD_W-1:0]    o_mid_ff, o_mid_in;
   logic [FIELD_W-1:0]    o_high_ff, o_high_in;

   logic                  rise;
   logic signed [WB:0]    span_s;
   logic signed [WB:0]    half_s;
   logic signed [WB:0]    mid_s;
   logic signed [SW-1:0]  db_hi, db_lo, r_s;
   logic                  in_band;

   assign rise             = req_pin_level & ~prev_ff;
   assign status.pulse_end = ~req_pin_level & prev_ff & armed_ff;

   // Centre recalculation, halving truncated toward zero
   assign span_s = $signed({1'b0, high_ff}) - $signed({1'b0, low_ff});
   assign half_s = (span_s + $signed({{WB{1'b0}}, span_s[WB]})) >>> 1;
   assign mid_s  = $signed({1'b0, low_ff}) + half_s;

   // Deadband window around the centre
   assign r_s     = $signed({2'b00, r_ff});
   assign db_hi   = $signed({2'b00, mid_ff}) + $signed(SW'(tolerance));
   assign db_lo   = $signed({2'b00, mid_ff}) - $signed(SW'(tolerance));
   assign in_band = (r_s <= db_hi) && (r_s >= db_lo);

   always_comb begin
      prev_in    = prev_ff;
      armed_in   = armed_ff;
      ticks_in   = ticks_ff;
      width_in   = width_ff;
      low_in     = low_ff;
      mid_in     = mid_ff;
      high_in    = high_ff;
      r_in       = r_ff;
      zero_in    = zero_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      quot_in    = quot_ff;
      o_width_in = o_width_ff;
      o_pct_in   = o_pct_ff;
      o_low_in   = o_low_ff;
      o_mid_in   = o_mid_ff;
      o_high_in  = o_high_ff;

      // register writes load the working bounds
      if (bound_wr.wr_low)  low_in  = WB'(bound_wr.data);
      if (bound_wr.wr_mid)  mid_in  = WB'(bound_wr.data);
      if (bound_wr.wr_high) high_in = WB'(bound_wr.data);

      // one tick per beat
      if (cmd.tick) begin
         prev_in = req_pin_level;
         if (rise) begin
            armed_in = 1'b1;
            ticks_in = COUNT_BITS'(1);
         end else if (req_pin_level && armed_ff) begin
            if (ticks_ff != {COUNT_BITS{1'b1}}) ticks_in = ticks_ff + 1'b1;
         end else if (status.pulse_end) begin
            armed_in = 1'b0;
            width_in = WB'(ticks_ff);
         end
      end

      // calibration widens the bounds, then re-centres
      if (cmd.cal_bound && calibrate) begin
         if (width_ff < low_ff)  low_in  = width_ff;
         if (width_ff > high_ff) high_in = width_ff;
      end
      if (cmd.cal_mid && calibrate) begin
         mid_in = mid_s[WB-1:0];
      end

      // clamp, low bound tested first
      if (cmd.clamp) begin
         if (width_ff < low_ff)       r_in = low_ff;
         else if (width_ff > high_ff) r_in = high_ff;
         else                         r_in = width_ff;
      end

      // numerator and aligned divisor
      if (cmd.scale) begin
         zero_in = in_band || (high_ff <= low_ff);
         rem_in  = NW'(r_ff - low_ff) * NW'(SCALE_SPAN);
         div_in  = NW'(high_ff - low_ff) << (QUOT_W - 1);
         quot_in = '0;
      end

      // restoring division, one quotient bit per step
      if (cmd.div_step) begin
         if (rem_ff >= div_ff) begin
            rem_in  = rem_ff - div_ff;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
         div_in = div_ff >> 1;
      end

      // result beat
      if (cmd.load_out) begin
         o_width_in = width_ff[FIELD_W-1:0];
         o_pct_in   = zero_ff ? '0 : PCT_W'(quot_ff - QUOT_W'(SCALE_OFFSET));
         o_low_in   = low_ff[FIELD_W-1:0];
         o_mid_in   = mid_ff[FIELD_W-1:0];
         o_high_in  = high_ff[FIELD_W-1:0];
      end
   end

   // Control and working state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         armed_ff <= 1'b0;
         ticks_ff <= '0;
         low_ff   <= WB'(LOW_RESET);
         mid_ff   <= WB'(MID_RESET);
         high_ff  <= WB'(HIGH_RESET);
      end else begin
         prev_ff  <= prev_in;
         armed_ff <= armed_in;
         ticks_ff <= ticks_in;
         low_ff   <= low_in;
         mid_ff   <= mid_in;
         high_ff  <= high_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      width_ff   <= width_in;
      r_ff       <= r_in;
      zero_ff    <= zero_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      quot_ff    <= quot_in;
      o_width_ff <= o_width_in;
      o_pct_ff   <= o_pct_in;
      o_low_ff   <= o_low_in;
      o_mid_ff   <= o_mid_in;
      o_high_ff  <= o_high_in;
   end

   assign rsp_pulse_width = o_width_ff;
   assign rsp_percent     = $signed(o_pct_ff);
   assign rsp_low_bound   = o_low_ff;
   assign rsp_mid_bound   = o_mid_ff;
   assign rsp_high_bound  = o_high_ff;

endmodule

FILE: src/rc_pulse_width_to_percent.sv
// Channel  Direction  Ports                        Beat
// req      in         req_valid/req_stall          one line sample per tick: pin_level
// rsp      out        rsp_valid/rsp_stall          pulse_width, percent, low/mid/high bound
// csr      in/out     csr_psel..csr_pready         5 word registers at byte address 4*i
//
// A tick that does not end a pulse leaves the sequencer idle; back to back ticks
// are taken. A falling edge that ends an armed pulse stalls ticks through bound
// update, centre, clamp, scale, 8 restoring division steps, load.
// The result sits in an output register, so ticks flow on while it waits; only a
// second result finding that register still full holds the sequencer.
// Reset is synchronous and restores the bounds to 1000/1500/2000.
module rc_pulse_width_to_percent #(
   parameter int COUNT_BITS = rpw_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_pin_level,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rpw_pkg::FIELD_W-1:0]     rsp_pulse_width,
   output logic signed [rpw_pkg::PCT_W-1:0] rsp_percent,
   output logic [rpw_pkg::FIELD_W-1:0]     rsp_low_bound,
   output logic [rpw_pkg::FIELD_W-1:0]     rsp_mid_bound,
   output logic [rpw_pkg::FIELD_W-1:0]     rsp_high_bound,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rpw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rpw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rpw_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rpw_pkg::*;

   bound_wr_type       bound_wr;
   logic [FIELD_W-1:0] tolerance;
   logic               calibrate;
   dp_cmd_type         cmd;
   dp_status_type      status;

   assign csr_pready = 1'b1;

   // Register block
   rpw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .bound_wr    (bound_wr),
      .tolerance   (tolerance),
      .calibrate   (calibrate)
   );

   // Sequencer
   rpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Counter, bounds and divider
   rpw_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pin_level   (req_pin_level),
      .bound_wr        (bound_wr),
      .tolerance       (tolerance),
      .calibrate       (calibrate),
      .rsp_pulse_width (rsp_pulse_width),
      .rsp_percent     (rsp_percent),
      .rsp_low_bound   (rsp_low_bound),
      .rsp_mid_bound   (rsp_mid_bound),
      .rsp_high_bound  (rsp_high_bound)
   );

endmodule
